// ===== src/lsfs_pkg.sv =====
`default_nettype none
package lsfs_pkg;

  localparam int NUM_LEDS_DEF   = 10;
  localparam int MAX_FRAMES_DEF = 64;

  localparam int HEAD_BYTES    = 4;
  localparam int TAIL_BYTES    = 8;
  localparam int BYTES_PER_LED = 4;
  localparam int COLOR_BYTES   = 3;
  localparam int CFG_W         = 7;

  localparam logic [7:0] MARK_BYTE = 8'hFF;
  localparam logic [7:0] ZERO_BYTE = 8'h00;

  typedef enum logic [2:0] {
    OP_SET_PIXEL = 3'd0,
    OP_CLEAR     = 3'd1,
    OP_SEND      = 3'd2,
    OP_LOAD      = 3'd3,
    OP_TICK      = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_BASE,
    ST_SEND
  } state_t;

  typedef enum logic [1:0] {
    BK_ZERO,
    BK_MARK,
    BK_DATA
  } byte_kind_t;

  // one byte slot of the strip frame as issued by the byte generator
  typedef struct packed {
    logic       valid;
    byte_kind_t kind;
    logic       last;
  } slot_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  led_index;
    logic [23:0] color;
    logic        write_now;
    logic [10:0] store_address;
    logic [7:0]  store_value;
  } cmd_t;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       last_byte;
  } result_t;

endpackage
`default_nettype wire

// ===== src/led_strip_frame_serializer.sv =====
`default_nettype none
// led strip frame serializer: commands arrive on start/cmd and are taken while busy is low.
// set pixel, clear and load touch the stores only; send, clear with write_now, set pixel
// with write_now on an led below NUM_LEDS, and tick put out a strip frame of 4*NUM_LEDS+12
// bytes, one byte per cycle on result with strobe high for exactly that cycle.
// the receiver cannot stall, so it must take every byte as it comes; last_byte marks the
// final byte. a send keeps busy high while the byte counter walks the frame. a tick first
// runs the remainder unit, one bit per cycle, then forms the base address in ST_BASE,
// then the same frame walk. bytes reach result through the output stage register.
// frames_in_use is to be written by the user through cfg_we/cfg_wdata only while the block
// is idle; the block itself does not enforce this. a tick with it at zero does nothing.
module led_strip_frame_serializer #(
  parameter int NUM_LEDS   = lsfs_pkg::NUM_LEDS_DEF,
  parameter int MAX_FRAMES = lsfs_pkg::MAX_FRAMES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire lsfs_pkg::cmd_t               cmd,
  output logic                              strobe,
  output lsfs_pkg::result_t                 result,
  input  wire logic                         cfg_we,
  input  wire logic [lsfs_pkg::CFG_W-1:0]   cfg_wdata
);
  import lsfs_pkg::*;

  localparam int PIX_BYTES   = NUM_LEDS * COLOR_BYTES;
  localparam int STORE_BYTES = MAX_FRAMES * PIX_BYTES;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int OFF_W       = $clog2(PIX_BYTES);
  localparam int IDX_W       = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int DW          = $clog2(MAX_FRAMES + 1);

  // configuration and control state
  logic [CFG_W-1:0] frames_in_use;
  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] frame_index;
  logic [AW-1:0]    base_addr;
  logic             from_frame;

  // stores
  logic [7:0] pix_store [PIX_BYTES];
  logic [7:0] frame_mem [STORE_BYTES];

  // decode of the incoming beat
  logic          accept;
  opcode_t       op;
  logic          set_ok;
  logic          load_ok;
  logic          go_send;
  logic          go_tick;
  logic [8:0]    fiu_wide;
  logic [DW-1:0] tick_count;

  // sequencing
  logic             gen_start;
  logic             mod_start;
  slot_t            slot;
  logic [OFF_W-1:0] byte_offset;
  logic             gen_done;
  logic             mod_done;
  logic [DW-1:0]    mod_rem;
  logic [OFF_W-1:0] pix_base;
  logic [AW-1:0]    rd_addr;

  // output stage
  slot_t      slot_q;
  logic       from_frame_q;
  logic [7:0] pix_q;
  logic [7:0] frame_q;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign op     = opcode_t'(cmd.opcode);

  // frames in use above the store size counts as the store size
  always_comb begin
    fiu_wide   = {2'b00, frames_in_use};
    tick_count = (fiu_wide > 9'(MAX_FRAMES)) ? DW'(MAX_FRAMES) : DW'(fiu_wide);
  end

  always_comb begin
    set_ok   = (cmd.led_index < 4'(NUM_LEDS));
    load_ok  = ({21'd0, cmd.store_address} < 32'(STORE_BYTES));
    pix_base = OFF_W'(6'(cmd.led_index) * 6'(COLOR_BYTES));
    go_send  = 1'b0;
    go_tick  = 1'b0;
    unique case (op)
      OP_SET_PIXEL: go_send = set_ok && cmd.write_now;
      OP_CLEAR:     go_send = cmd.write_now;
      OP_SEND:      go_send = 1'b1;
      OP_LOAD:      go_send = 1'b0;
      OP_TICK:      go_tick = (tick_count != '0);
      default:      go_send = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && go_tick) begin
          state_next = ST_MOD;
        end else if (accept && go_send) begin
          state_next = ST_SEND;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          state_next = ST_BASE;
        end
      end
      ST_BASE: state_next = ST_SEND;
      ST_SEND: begin
        if (gen_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    gen_start = 1'b0;
    mod_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        gen_start = accept && go_send;
        mod_start = accept && go_tick;
      end
      ST_MOD:  gen_start = 1'b0;
      ST_BASE: gen_start = 1'b1;
      ST_SEND: gen_start = 1'b0;
      default: gen_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      frames_in_use <= '0;
      frame_index   <= '0;
      from_frame    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        frames_in_use <= cfg_wdata;
      end
      if (accept) begin
        from_frame <= go_tick;
      end
      if (state == ST_MOD && mod_done) begin
        frame_index <= mod_rem[IDX_W-1:0];
      end
    end
  end

  // base address of the chosen frame, one constant multiply
  always_ff @(posedge clk) begin
    if (state == ST_BASE) begin
      base_addr <= AW'(32'(frame_index) * 32'(PIX_BYTES));
    end
  end

  // pixel store, cleared at reset and by the clear command
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < PIX_BYTES; j++) begin
        pix_store[j] <= '0;
      end
    end else if (accept && op == OP_CLEAR) begin
      for (int j = 0; j < PIX_BYTES; j++) begin
        pix_store[j] <= '0;
      end
    end else if (accept && op == OP_SET_PIXEL && set_ok) begin
      pix_store[pix_base]             <= cmd.color[23:16];
      pix_store[pix_base + OFF_W'(1)] <= cmd.color[15:8];
      pix_store[pix_base + OFF_W'(2)] <= cmd.color[7:0];
    end
  end

  // animation frame store
  assign rd_addr = base_addr + AW'(byte_offset);

  always_ff @(posedge clk) begin
    if (accept && op == OP_LOAD && load_ok) begin
      frame_mem[AW'(cmd.store_address)] <= cmd.store_value;
    end
    frame_q <= frame_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    pix_q <= pix_store[byte_offset];
  end

  lsfs_mod_unit #(
    .DW (DW)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (DW'(frame_index) + DW'(1)),
    .divisor   (tick_count),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  lsfs_byte_gen #(
    .NUM_LEDS (NUM_LEDS)
  ) u_gen (
    .clk         (clk),
    .rst         (rst),
    .start       (gen_start),
    .slot        (slot),
    .byte_offset (byte_offset),
    .done        (gen_done)
  );

  // output stage lines up with the registered store reads
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot;
    end
    from_frame_q <= from_frame;
  end

  always_comb begin
    strobe           = slot_q.valid;
    result.last_byte = slot_q.valid && slot_q.last;
    case (slot_q.kind)
      BK_MARK: result.spi_byte = MARK_BYTE;
      BK_DATA: result.spi_byte = from_frame_q ? frame_q : pix_q;
      default: result.spi_byte = ZERO_BYTE;
    endcase
  end

  // bytes only come out of a frame walk
  a_strobe_in_send: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state == ST_SEND))
    else $error("result beat outside a frame walk");

  // remainder unit reports only while a tick waits on it
  a_mod_done_in_mod: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == ST_MOD))
    else $error("remainder done outside tick");

  // the advanced frame index lies below the frame count
  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BASE) |-> (DW'(frame_index) < tick_count))
    else $error("frame index out of range");

endmodule
`default_nettype wire

// ===== src/lsfs_mod_unit.sv =====
`default_nettype none
module lsfs_mod_unit #(
  parameter int DW = 7
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      remainder
);
  import lsfs_pkg::*;

  localparam int SW = (DW > 1) ? $clog2(DW) : 1;

  logic          running;
  logic [SW-1:0] step;
  logic [DW-1:0] dvd;
  logic [DW-1:0] dvs;
  logic [DW-1:0] rem;
  logic [DW:0]   trial;
  logic [DW-1:0] rem_next;
  logic          last_step;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    trial     = {rem, dvd[DW-1]};
    rem_next  = (trial >= {1'b0, dvs}) ? DW'(trial - {1'b0, dvs}) : DW'(trial);
    last_step = (step == SW'(DW - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= running && last_step;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + SW'(1);
        if (last_step) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (running) begin
      dvd <= dvd << 1;
      rem <= rem_next;
    end
  end

  assign remainder = rem;

endmodule
`default_nettype wire

// ===== src/lsfs_byte_gen.sv =====
`default_nettype none
module lsfs_byte_gen #(
  parameter int NUM_LEDS = lsfs_pkg::NUM_LEDS_DEF
) (
  input  wire logic                                           clk,
  input  wire logic                                           rst,
  input  wire logic                                           start,
  output lsfs_pkg::slot_t                                     slot,
  output logic [$clog2(NUM_LEDS * lsfs_pkg::COLOR_BYTES)-1:0] byte_offset,
  output logic                                                done
);
  import lsfs_pkg::*;

  localparam int PIX_BYTES = NUM_LEDS * COLOR_BYTES;
  localparam int OFF_W     = $clog2(PIX_BYTES);
  localparam int TOTAL     = HEAD_BYTES + BYTES_PER_LED * NUM_LEDS + TAIL_BYTES;
  localparam int CNT_W     = $clog2(TOTAL);
  localparam int LED_END   = HEAD_BYTES + BYTES_PER_LED * NUM_LEDS;

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [1:0]       sub;
  logic [OFF_W-1:0] led_off;
  logic             in_head;
  logic             in_led;
  logic             is_last;

  always_comb begin
    in_head = (cnt < CNT_W'(HEAD_BYTES));
    in_led  = !in_head && (cnt < CNT_W'(LED_END));
    is_last = (cnt == CNT_W'(TOTAL - 1));
    slot.valid = running;
    slot.last  = running && is_last;
    if (in_led) begin
      slot.kind = (sub == 2'd0) ? BK_MARK : BK_DATA;
    end else begin
      slot.kind = BK_ZERO;
    end
    // blue, green, red order within one led
    case (sub)
      2'd1:    byte_offset = led_off + OFF_W'(2);
      2'd2:    byte_offset = led_off + OFF_W'(1);
      default: byte_offset = led_off;
    endcase
    done = running && is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
      sub     <= '0;
      led_off <= '0;
    end else if (start) begin
      running <= 1'b1;
      cnt     <= '0;
      sub     <= '0;
      led_off <= '0;
    end else if (running) begin
      cnt <= cnt + CNT_W'(1);
      if (is_last) begin
        running <= 1'b0;
      end
      if (in_led) begin
        sub <= sub + 2'd1;
        if (sub == 2'd3) begin
          led_off <= (led_off == OFF_W'(PIX_BYTES - COLOR_BYTES)) ? '0
                                                                   : led_off + OFF_W'(COLOR_BYTES);
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== tb/led_strip_frame_serializer_tb.sv =====
`timescale 1ns / 1ps
module led_strip_frame_serializer_tb;
  import lsfs_pkg::*;

  localparam int NUM_LEDS    = NUM_LEDS_DEF;
  localparam int MAX_FRAMES  = MAX_FRAMES_DEF;
  localparam int PIX_BYTES   = NUM_LEDS * COLOR_BYTES;
  localparam int STORE_BYTES = MAX_FRAMES * PIX_BYTES;

  // opcodes 5..7 have no name in the package; the block must ignore them
  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;

  // frames loaded up front, enough for every directed tick
  localparam int FILL_FRAMES = 5;

  // settle time after the last byte: remainder unit, base cycle and the walk lead-in
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 400000;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  cmd_t cmd_in;
  logic strobe;
  result_t dut_result;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  // shadow of the block: pixel store, animation store, frame pointer, frame count
  logic [7:0] pixel_shadow [PIX_BYTES];
  logic [7:0] anim_shadow [STORE_BYTES];
  bit anim_written [STORE_BYTES];
  int unsigned anim_pos;
  logic [CFG_W-1:0] frames_shadow;

  // strip bytes still owed by the block, oldest first
  result_t strip_bytes_q [$];

  int errors = 0;
  int cycle_count = 0;
  int send_idle_pct;

  led_strip_frame_serializer u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd_in),
    .strobe(strobe),
    .result(dut_result),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // hard stop in case the block hangs or drops bytes
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t timeout with %0d strip bytes outstanding", $time, strip_bytes_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int exp_v, input int act_v);
    errors++;
    $display("%0t mismatch %s: expected %0h actual %0h", $time, what, exp_v, act_v);
  endtask

  // every strobed beat is compared against the oldest owed strip byte
  always @(posedge clk) begin
    result_t want;
    if (!rst && strobe) begin
      if (strip_bytes_q.size() == 0) begin
        report_mismatch("unexpected beat (spi_byte)", 0, dut_result.spi_byte);
      end else begin
        want = strip_bytes_q.pop_front();
        if (dut_result.spi_byte !== want.spi_byte)
          report_mismatch("spi_byte", want.spi_byte, dut_result.spi_byte);
        if (dut_result.last_byte !== want.last_byte)
          report_mismatch("last_byte", want.last_byte, dut_result.last_byte);
      end
    end
  end

  // byte idx of the rgb image, either the pixel store or one animation frame
  function automatic logic [7:0] image_byte(input bit from_anim, input int unsigned idx);
    return from_anim ? anim_shadow[idx] : pixel_shadow[idx];
  endfunction

  // first byte of a frame that was never loaded, or -1 once the frame is complete
  function automatic int frame_hole(input int unsigned frame);
    for (int k = 0; k < PIX_BYTES; k++)
      if (!anim_written[frame * PIX_BYTES + k]) return k;
    return -1;
  endfunction

  // queue one whole strip frame: start zeros, mark/blue/green/red per led, end zeros
  task automatic queue_strip(input bit from_anim, input int unsigned base);
    result_t r;
    r.last_byte = 1'b0;
    r.spi_byte = ZERO_BYTE;
    repeat (HEAD_BYTES) strip_bytes_q.push_back(r);
    for (int led = 0; led < NUM_LEDS; led++) begin
      r.spi_byte = MARK_BYTE;
      strip_bytes_q.push_back(r);
      r.spi_byte = image_byte(from_anim, base + led * COLOR_BYTES + 2);
      strip_bytes_q.push_back(r);
      r.spi_byte = image_byte(from_anim, base + led * COLOR_BYTES + 1);
      strip_bytes_q.push_back(r);
      r.spi_byte = image_byte(from_anim, base + led * COLOR_BYTES);
      strip_bytes_q.push_back(r);
    end
    r.spi_byte = ZERO_BYTE;
    for (int i = 0; i < TAIL_BYTES; i++) begin
      r.last_byte = (i == TAIL_BYTES - 1);
      strip_bytes_q.push_back(r);
    end
  endtask

  // advance the shadow for one accepted command; did_work is low when it was ignored
  task automatic apply_command(input cmd_t c, output bit did_work);
    int unsigned frames;
    did_work = 1'b0;
    case (c.opcode)
      OP_SET_PIXEL: begin
        if (c.led_index < NUM_LEDS) begin
          pixel_shadow[c.led_index * COLOR_BYTES]     = c.color[23:16];
          pixel_shadow[c.led_index * COLOR_BYTES + 1] = c.color[15:8];
          pixel_shadow[c.led_index * COLOR_BYTES + 2] = c.color[7:0];
          if (c.write_now) queue_strip(1'b0, 0);
          did_work = 1'b1;
        end
      end
      OP_CLEAR: begin
        foreach (pixel_shadow[i]) pixel_shadow[i] = ZERO_BYTE;
        if (c.write_now) queue_strip(1'b0, 0);
        did_work = 1'b1;
      end
      OP_SEND: begin
        queue_strip(1'b0, 0);
        did_work = 1'b1;
      end
      OP_LOAD: begin
        if (c.store_address < STORE_BYTES) begin
          anim_shadow[c.store_address] = c.store_value;
          anim_written[c.store_address] = 1'b1;
          did_work = 1'b1;
        end
      end
      OP_TICK: begin
        // counts above the store size saturate
        frames = (frames_shadow > MAX_FRAMES) ? MAX_FRAMES : frames_shadow;
        if (frames != 0) begin
          anim_pos = (anim_pos + 1) % frames;
          queue_strip(1'b1, anim_pos * PIX_BYTES);
          did_work = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  // one command beat: optional idle gap, then hold start until busy is low at an edge
  task automatic send_command(input cmd_t c, output bit did_work);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    cmd_in <= c;
    do @(posedge clk); while (busy);
    apply_command(c, did_work);
  endtask

  function automatic cmd_t make_cmd(input logic [2:0] op, input logic [3:0] led,
                                    input logic [23:0] color, input logic write_now,
                                    input logic [10:0] addr, input logic [7:0] value);
    cmd_t c;
    c.opcode = op;
    c.led_index = led;
    c.color = color;
    c.write_now = write_now;
    c.store_address = addr;
    c.store_value = value;
    return c;
  endfunction

  task automatic issue(input logic [2:0] op, input logic [3:0] led, input logic [23:0] color,
                       input logic write_now, input logic [10:0] addr, input logic [7:0] value);
    bit did_work;
    send_command(make_cmd(op, led, color, write_now, addr, value), did_work);
  endtask

  // drop start, wait for every owed byte, then let the block settle back to idle
  task automatic wait_strip_done();
    @(negedge clk);
    start <= 1'b0;
    while (strip_bytes_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_frames_in_use(input logic [CFG_W-1:0] value);
    wait_strip_done();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    frames_shadow = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // strip straight out of reset must be all dark
  task automatic test_reset_send();
    issue(OP_SEND, '0, '0, 1'b0, '0, '0);
  endtask

  task automatic test_set_pixel_extremes();
    issue(OP_SET_PIXEL, 4'd0, 24'hFFFFFF, 1'b1, '0, '0);
    issue(OP_SET_PIXEL, 4'(NUM_LEDS - 1), 24'h123456, 1'b0, '1, '1);
    issue(OP_SET_PIXEL, 4'(NUM_LEDS - 1), 24'hFF00A5, 1'b1, '0, '0);
    issue(OP_SET_PIXEL, 4'd5, 24'h000000, 1'b1, '1, '1);
  endtask

  task automatic test_ignored_commands();
    // led past the strip end, even with write_now
    issue(OP_SET_PIXEL, 4'(NUM_LEDS), 24'hABCDEF, 1'b1, '0, '0);
    issue(OP_SET_PIXEL, 4'hF, 24'hFFFFFF, 1'b1, '1, '1);
    for (int k = 0; k < 3; k++)
      issue(3'(OP_FIRST_UNUSED + k), 4'd1, 24'h5A5A5A, 1'b1, '1, '1);
    // loads past the store end
    issue(OP_LOAD, '0, '0, 1'b0, 11'(STORE_BYTES), 8'h77);
    issue(OP_LOAD, '0, '0, 1'b0, '1, '1);
    // no frames in use yet, so a tick is a no-op
    issue(OP_TICK, '0, '0, 1'b1, '0, '0);
    issue(OP_SEND, '0, '0, 1'b0, '0, '0);
  endtask

  task automatic test_clear();
    issue(OP_CLEAR, '0, '0, 1'b0, '0, '0);
    issue(OP_SEND, '0, '0, 1'b0, '0, '0);
    issue(OP_SET_PIXEL, 4'd3, 24'h80FF01, 1'b0, '0, '0);
    issue(OP_CLEAR, '1, '1, 1'b1, '1, '1);
  endtask

  // the first frames get every byte written; later ticks only land on complete frames
  task automatic test_frame_store_fill();
    for (int a = 0; a < FILL_FRAMES * PIX_BYTES; a++)
      issue(OP_LOAD, 4'($urandom), 24'($urandom), 1'($urandom), 11'(a), 8'($urandom));
  endtask

  task automatic test_animation_ticks();
    write_frames_in_use(7'd1);
    issue(OP_TICK, '0, '0, 1'b0, '0, '0);
    issue(OP_TICK, '0, '0, 1'b0, '0, '0);
    write_frames_in_use(7'(MAX_FRAMES));
    repeat (3) issue(OP_TICK, '0, '0, 1'b0, '0, '0);
    // over-range count saturates at the store size
    write_frames_in_use('1);
    issue(OP_TICK, '0, '0, 1'b0, '0, '0);
    // shrink below the current frame pointer, wrap must still land in range
    write_frames_in_use(7'd3);
    issue(OP_TICK, '0, '0, 1'b0, '0, '0);
    write_frames_in_use(7'd2);
    issue(OP_TICK, '0, '0, 1'b0, '0, '0);
  endtask

  function automatic cmd_t random_cmd();
    cmd_t c;
    int sel;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    c = cmd_t'(raw[$bits(cmd_t)-1:0]);
    sel = $urandom_range(99);
    if (sel < 25) begin
      c.opcode = OP_SET_PIXEL;
      c.led_index = ($urandom_range(7) == 0) ? 4'($urandom_range(15, NUM_LEDS))
                                             : 4'($urandom_range(NUM_LEDS - 1));
      c.write_now = ($urandom_range(2) == 0);
    end else if (sel < 31) begin
      c.opcode = OP_CLEAR;
    end else if (sel < 43) begin
      c.opcode = OP_SEND;
    end else if (sel < 70) begin
      c.opcode = OP_LOAD;
    end else if (sel < 95) begin
      c.opcode = OP_TICK;
    end else begin
      c.opcode = 3'(OP_FIRST_UNUSED + $urandom_range(2));
    end
    return c;
  endfunction

  function automatic logic [CFG_W-1:0] pick_frame_count();
    case ($urandom_range(9))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd2;
      3: return 7'(MAX_FRAMES - 1);
      4: return 7'(MAX_FRAMES);
      5: return 7'(MAX_FRAMES + 1);
      6: return '1;
      default: return 7'($urandom);
    endcase
  endfunction

  // random traffic; the frame count is rewritten every 40 effective commands
  task automatic test_random_traffic(input int n_items, input int idle_pct);
    int done;
    bit did_work;
    cmd_t c;
    int unsigned frames;
    int unsigned next_pos;
    int hole;
    send_idle_pct = idle_pct;
    done = 0;
    while (done < n_items) begin
      c = random_cmd();
      // a tick must not land on a frame with unloaded bytes, load one of them instead
      if (c.opcode == OP_TICK) begin
        frames = (frames_shadow > MAX_FRAMES) ? MAX_FRAMES : frames_shadow;
        if (frames != 0) begin
          next_pos = (anim_pos + 1) % frames;
          hole = frame_hole(next_pos);
          if (hole >= 0) begin
            c.opcode = OP_LOAD;
            c.store_address = 11'(next_pos * PIX_BYTES + hole);
          end
        end
      end
      send_command(c, did_work);
      if (did_work) begin
        done++;
        if (done % 40 == 0) write_frames_in_use(pick_frame_count());
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd_in = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    send_idle_pct = 16;
    foreach (pixel_shadow[i]) pixel_shadow[i] = ZERO_BYTE;
    foreach (anim_shadow[i]) anim_shadow[i] = ZERO_BYTE;
    anim_pos = 0;
    frames_shadow = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_frames_in_use('0);
    test_reset_send();
    test_set_pixel_extremes();
    test_ignored_commands();
    test_clear();
    // sender holds off until the strip is fully out before filling the store
    wait_strip_done();
    test_frame_store_fill();
    test_animation_ticks();
    test_random_traffic(60, 16);
    test_random_traffic(60, 56);
    test_random_traffic(60, 0);

    wait_strip_done();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
